// File: src/imds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imds_pkg
// Shared types and constants of the inline markup delimiter scanner.
// ----------------------------------------------------------------------------
package imds_pkg;

  localparam int CHAR_W  = 21;
  localparam int SKIP_W  = 16;
  localparam int MASK_W  = 8;
  localparam int KIND_W  = 3;
  localparam int LEN_W   = 2;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // ascii codes of the characters the scanner cares about
  localparam logic [6:0] CH_TAB    = 7'h09;
  localparam logic [6:0] CH_LF     = 7'h0A;
  localparam logic [6:0] CH_CR     = 7'h0D;
  localparam logic [6:0] CH_SPACE  = 7'h20;
  localparam logic [6:0] CH_DQUOTE = 7'h22;
  localparam logic [6:0] CH_HASH   = 7'h23;
  localparam logic [6:0] CH_SQUOTE = 7'h27;
  localparam logic [6:0] CH_STAR   = 7'h2A;
  localparam logic [6:0] CH_PLUS   = 7'h2B;
  localparam logic [6:0] CH_DIG_LO = 7'h30;
  localparam logic [6:0] CH_DIG_HI = 7'h39;
  localparam logic [6:0] CH_UPP_LO = 7'h41;
  localparam logic [6:0] CH_UPP_HI = 7'h5A;
  localparam logic [6:0] CH_BSLASH = 7'h5C;
  localparam logic [6:0] CH_UNDER  = 7'h5F;
  localparam logic [6:0] CH_TICK   = 7'h60;
  localparam logic [6:0] CH_LOW_LO = 7'h61;
  localparam logic [6:0] CH_LOW_HI = 7'h7A;

  // token kinds, also bit positions in the accept mask
  localparam logic [KIND_W-1:0] KIND_EOF       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HARDWRAP  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EMPHASIS  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ITALIC    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MONO      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_HIGHLIGHT = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DQUOTE    = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SQUOTE    = 3'd7;

  localparam logic [LEN_W-1:0] LEN_NONE   = 2'd0;
  localparam logic [LEN_W-1:0] LEN_SINGLE = 2'd1;
  localparam logic [LEN_W-1:0] LEN_DOUBLE = 2'd2;

  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_WORD,
    CLS_BLANK,
    CLS_EOL,
    CLS_STAR,
    CLS_UNDER,
    CLS_TICK,
    CLS_HASH,
    CLS_DQUOTE,
    CLS_SQUOTE,
    CLS_BSLASH,
    CLS_PLUS,
    CLS_EOF
  } char_cls_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SKIP,
    PH_HW_AFTER,
    PH_C_AFTER,
    PH_C_SCAN,
    PH_C_CLOSE,
    PH_T_TICK,
    PH_T_AFTER,
    PH_T_SCAN,
    PH_T_CLOSE
  } phase_t;

  // classified item passed from front to back
  typedef struct packed {
    logic              start;
    logic [MASK_W-1:0] mask;
    logic              col_zero;
    char_cls_t         cls;
  } entry_t;

  typedef struct packed {
    logic              found;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  len;
    logic [SKIP_W-1:0] skipped;
  } result_t;

endpackage

// File: src/imds_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imds channel interfaces
// Valid/ready channels for scanner characters and scan results.
// ----------------------------------------------------------------------------
interface imds_in_if;
  logic                        valid;
  logic                        ready;
  logic                        start_scan;
  logic [imds_pkg::MASK_W-1:0] valid_mask;
  logic                        at_column_zero;
  logic [imds_pkg::CHAR_W-1:0] char_code;
  logic                        is_eof;

  modport source (output valid, start_scan, valid_mask, at_column_zero, char_code,
                  is_eof, input ready);
  modport sink (input valid, start_scan, valid_mask, at_column_zero, char_code,
                is_eof, output ready);
endinterface

interface imds_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [imds_pkg::KIND_W-1:0] token_kind;
  logic [imds_pkg::LEN_W-1:0]  token_length;
  logic [imds_pkg::SKIP_W-1:0] skipped_count;

  modport source (output valid, found, token_kind, token_length, skipped_count,
                  input ready);
  modport sink (input valid, found, token_kind, token_length, skipped_count,
                output ready);
endinterface

// File: src/imds_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imds_front
// Accepts characters and reduces each to a small character class.
// ----------------------------------------------------------------------------
module imds_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_start_scan,
  input  logic [imds_pkg::MASK_W-1:0] in_valid_mask,
  input  logic                        in_at_column_zero,
  input  logic [imds_pkg::CHAR_W-1:0] in_char_code,
  input  logic                        in_is_eof,
  input  logic                        q_full,
  output logic                        q_push,
  output imds_pkg::entry_t            q_entry
);

  imds_pkg::char_cls_t cls;

  always_comb begin
    if (in_is_eof) begin
      cls = imds_pkg::CLS_EOF;
    end else if (|in_char_code[imds_pkg::CHAR_W-1:7]) begin
      cls = imds_pkg::CLS_OTHER;  // wide code points never match
    end else begin
      case (in_char_code[6:0]) inside
        imds_pkg::CH_SPACE, imds_pkg::CH_TAB: cls = imds_pkg::CLS_BLANK;
        imds_pkg::CH_LF, imds_pkg::CH_CR:     cls = imds_pkg::CLS_EOL;
        [imds_pkg::CH_DIG_LO:imds_pkg::CH_DIG_HI],
        [imds_pkg::CH_UPP_LO:imds_pkg::CH_UPP_HI],
        [imds_pkg::CH_LOW_LO:imds_pkg::CH_LOW_HI]: cls = imds_pkg::CLS_WORD;
        imds_pkg::CH_STAR:   cls = imds_pkg::CLS_STAR;
        imds_pkg::CH_UNDER:  cls = imds_pkg::CLS_UNDER;
        imds_pkg::CH_TICK:   cls = imds_pkg::CLS_TICK;
        imds_pkg::CH_HASH:   cls = imds_pkg::CLS_HASH;
        imds_pkg::CH_DQUOTE: cls = imds_pkg::CLS_DQUOTE;
        imds_pkg::CH_SQUOTE: cls = imds_pkg::CLS_SQUOTE;
        imds_pkg::CH_BSLASH: cls = imds_pkg::CLS_BSLASH;
        imds_pkg::CH_PLUS:   cls = imds_pkg::CLS_PLUS;
        default:             cls = imds_pkg::CLS_OTHER;
      endcase
    end
  end

  assign in_ready          = !q_full;
  assign q_push            = in_valid && !q_full;
  assign q_entry.start     = in_start_scan;
  assign q_entry.mask      = in_valid_mask;
  assign q_entry.col_zero  = in_at_column_zero;
  assign q_entry.cls       = cls;

endmodule

// File: src/imds_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imds_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module imds_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  imds_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output imds_pkg::entry_t pop_entry,
  output logic             empty
);

  imds_pkg::entry_t                 slots_r [imds_pkg::Q_DEPTH];
  logic [imds_pkg::Q_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [imds_pkg::Q_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [imds_pkg::Q_CNT_W-1:0]     count_r, count_nxt;

  assign full      = (count_r == imds_pkg::Q_CNT_W'(imds_pkg::Q_DEPTH));
  assign empty     = (count_r == '0);
  assign pop_entry = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == imds_pkg::Q_PTR_W'(imds_pkg::Q_DEPTH - 1)) ? '0
                 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == imds_pkg::Q_PTR_W'(imds_pkg::Q_DEPTH - 1)) ? '0
                 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: src/imds_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imds_back
// Scan state machine, one classified item per cycle while no result waits, with result register.
// ----------------------------------------------------------------------------
module imds_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  imds_pkg::entry_t  q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output imds_pkg::result_t out_result
);

  imds_pkg::phase_t            phase_r, phase_nxt;
  logic                        line_start_r, line_start_nxt;
  logic                        space_seen_r, space_seen_nxt;
  logic [imds_pkg::SKIP_W-1:0] skip_r, skip_nxt;
  imds_pkg::char_cls_t         delim_r, delim_nxt;
  logic [imds_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic                        prev_bs_r, prev_bs_nxt;
  logic                        prev_blank_r, prev_blank_nxt;
  logic [imds_pkg::MASK_W-1:0] mask_r, mask_nxt;
  logic                        out_valid_r, out_valid_nxt;
  imds_pkg::result_t           result_r, result_nxt;

  imds_pkg::phase_t            ph;
  imds_pkg::char_cls_t         cls;
  logic                        is_eof, is_eol, is_blank;
  logic                        emit;
  logic                        emit_found;
  logic [imds_pkg::KIND_W-1:0] emit_kind;
  logic [imds_pkg::LEN_W-1:0]  emit_len;
  logic                        do_scan;

  assign q_pop      = !q_empty && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;
  assign out_result = result_r;

  assign cls      = q_entry.cls;
  assign is_eof   = (cls == imds_pkg::CLS_EOF);
  assign is_eol   = (cls == imds_pkg::CLS_EOL);
  assign is_blank = (cls == imds_pkg::CLS_BLANK);

  always_comb begin
    // a start item reloads the scan context before it is examined
    if (q_entry.start) begin
      ph             = imds_pkg::PH_SKIP;
      line_start_nxt = q_entry.col_zero;
      space_seen_nxt = 1'b0;
      skip_nxt       = '0;
      delim_nxt      = imds_pkg::CLS_OTHER;
      kind_nxt       = imds_pkg::KIND_EOF;
      prev_bs_nxt    = 1'b0;
      prev_blank_nxt = 1'b0;
      mask_nxt       = q_entry.mask;
    end else begin
      ph             = phase_r;
      line_start_nxt = line_start_r;
      space_seen_nxt = space_seen_r;
      skip_nxt       = skip_r;
      delim_nxt      = delim_r;
      kind_nxt       = kind_r;
      prev_bs_nxt    = prev_bs_r;
      prev_blank_nxt = prev_blank_r;
      mask_nxt       = mask_r;
    end
    phase_nxt  = ph;
    emit       = 1'b0;
    emit_found = 1'b0;
    emit_kind  = imds_pkg::KIND_EOF;
    emit_len   = imds_pkg::LEN_NONE;
    do_scan    = 1'b0;

    case (ph)
      imds_pkg::PH_SKIP: begin
        if (is_blank || is_eol) begin
          if (is_eol) begin
            space_seen_nxt = 1'b0;
            line_start_nxt = 1'b1;
          end else if (!line_start_nxt) begin
            space_seen_nxt = 1'b1;
          end
          if (skip_nxt != '1) begin
            skip_nxt = skip_nxt + 1'b1;
          end
        end else if (mask_nxt[imds_pkg::KIND_HARDWRAP] && space_seen_nxt &&
                     cls == imds_pkg::CLS_PLUS) begin
          phase_nxt = imds_pkg::PH_HW_AFTER;
        end else if ((mask_nxt[imds_pkg::KIND_EMPHASIS] && cls == imds_pkg::CLS_STAR) ||
                     (mask_nxt[imds_pkg::KIND_ITALIC] && cls == imds_pkg::CLS_UNDER) ||
                     (mask_nxt[imds_pkg::KIND_MONO] && cls == imds_pkg::CLS_TICK) ||
                     (mask_nxt[imds_pkg::KIND_HIGHLIGHT] && cls == imds_pkg::CLS_HASH)) begin
          delim_nxt = cls;
          kind_nxt  = (cls == imds_pkg::CLS_STAR)  ? imds_pkg::KIND_EMPHASIS
                    : (cls == imds_pkg::CLS_UNDER) ? imds_pkg::KIND_ITALIC
                    : (cls == imds_pkg::CLS_TICK)  ? imds_pkg::KIND_MONO
                    : imds_pkg::KIND_HIGHLIGHT;
          phase_nxt = imds_pkg::PH_C_AFTER;
        end else if ((mask_nxt[imds_pkg::KIND_DQUOTE] && cls == imds_pkg::CLS_DQUOTE) ||
                     (mask_nxt[imds_pkg::KIND_SQUOTE] && cls == imds_pkg::CLS_SQUOTE)) begin
          delim_nxt = cls;
          kind_nxt  = (cls == imds_pkg::CLS_DQUOTE) ? imds_pkg::KIND_DQUOTE
                    : imds_pkg::KIND_SQUOTE;
          phase_nxt = imds_pkg::PH_T_TICK;
        end else begin
          emit       = 1'b1;
          emit_found = is_eof && mask_nxt[imds_pkg::KIND_EOF];
        end
      end
      imds_pkg::PH_HW_AFTER: begin
        emit = 1'b1;
        if (is_eof || is_eol) begin
          emit_found = 1'b1;
          emit_kind  = imds_pkg::KIND_HARDWRAP;
          emit_len   = imds_pkg::LEN_SINGLE;
        end
      end
      imds_pkg::PH_C_AFTER: begin
        if (is_eof || cls == delim_nxt || is_blank || is_eol) begin
          emit = 1'b1;
        end else begin
          prev_bs_nxt    = (cls == imds_pkg::CLS_BSLASH);
          prev_blank_nxt = is_blank;
          phase_nxt      = imds_pkg::PH_C_SCAN;
        end
      end
      imds_pkg::PH_C_CLOSE: begin
        if (cls != delim_nxt && cls != imds_pkg::CLS_WORD) begin
          emit       = 1'b1;
          emit_found = 1'b1;
          emit_kind  = kind_nxt;
          emit_len   = imds_pkg::LEN_SINGLE;
        end else begin
          // not a close: the delimiter counts as ordinary content
          prev_bs_nxt    = 1'b0;
          prev_blank_nxt = 1'b0;
          phase_nxt      = imds_pkg::PH_C_SCAN;
          do_scan        = 1'b1;
        end
      end
      imds_pkg::PH_C_SCAN: begin
        do_scan = 1'b1;
      end
      imds_pkg::PH_T_TICK: begin
        if (cls != imds_pkg::CLS_TICK) begin
          emit = 1'b1;
        end else begin
          phase_nxt = imds_pkg::PH_T_AFTER;
        end
      end
      imds_pkg::PH_T_AFTER: begin
        if (is_eof || is_blank || is_eol || cls == imds_pkg::CLS_TICK) begin
          emit = 1'b1;
        end else begin
          prev_bs_nxt    = (cls == imds_pkg::CLS_BSLASH);
          prev_blank_nxt = is_blank;
          phase_nxt      = imds_pkg::PH_T_SCAN;
        end
      end
      imds_pkg::PH_T_SCAN: begin
        if (is_eof || is_eol) begin
          emit = 1'b1;
        end else if (cls == imds_pkg::CLS_TICK && !prev_bs_nxt) begin
          phase_nxt = imds_pkg::PH_T_CLOSE;
        end else begin
          prev_bs_nxt    = (cls == imds_pkg::CLS_BSLASH);
          prev_blank_nxt = is_blank;
        end
      end
      imds_pkg::PH_T_CLOSE: begin
        emit = 1'b1;
        if (cls == delim_nxt) begin
          emit_found = 1'b1;
          emit_kind  = kind_nxt;
          emit_len   = imds_pkg::LEN_DOUBLE;
        end
      end
      default: begin
        phase_nxt = imds_pkg::PH_IDLE;
      end
    endcase

    // body of a constrained span, shared by scan and a failed close
    if (do_scan) begin
      if (is_eof || is_eol) begin
        emit = 1'b1;
      end else if (cls == delim_nxt && !prev_bs_nxt && !prev_blank_nxt) begin
        phase_nxt = imds_pkg::PH_C_CLOSE;
      end else begin
        prev_bs_nxt    = (cls == imds_pkg::CLS_BSLASH);
        prev_blank_nxt = is_blank;
      end
    end

    if (emit) begin
      phase_nxt = imds_pkg::PH_IDLE;
    end

    result_nxt = result_r;
    if (q_pop && emit) begin
      out_valid_nxt      = 1'b1;
      result_nxt.found   = emit_found;
      result_nxt.kind    = emit_kind;
      result_nxt.len     = emit_len;
      result_nxt.skipped = skip_nxt;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= imds_pkg::PH_IDLE;
      line_start_r <= 1'b0;
      space_seen_r <= 1'b0;
      skip_r       <= '0;
      delim_r      <= imds_pkg::CLS_OTHER;
      kind_r       <= imds_pkg::KIND_EOF;
      prev_bs_r    <= 1'b0;
      prev_blank_r <= 1'b0;
      mask_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        phase_r      <= phase_nxt;
        line_start_r <= line_start_nxt;
        space_seen_r <= space_seen_nxt;
        skip_r       <= skip_nxt;
        delim_r      <= delim_nxt;
        kind_r       <= kind_nxt;
        prev_bs_r    <= prev_bs_nxt;
        prev_blank_r <= prev_blank_nxt;
        mask_r       <= mask_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

endmodule

// File: src/inline_markup_delimiter_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inline_markup_delimiter_scanner
// Streams the characters of one scan call and reports the delimiter found.
// ----------------------------------------------------------------------------
// usage:
//   in_chan carries one character item per handshake; the first item of a
//   scan call has start_scan set and brings the token mask and column flag.
//   out_chan gives one result per scan call once the decision is reached:
//   found, token kind and length, and the saturating count of skipped
//   whitespace. items after the decision are dropped until the next start.
// timing:
//   one item per cycle sustained while out_chan takes results. the front
//   classifies the character in the accept cycle and writes a two-entry queue;
//   the back state machine takes one queued item per cycle while no result
//   waits; a deciding item is stored in the queue, then in the result register.
// stall:
//   a waiting result sits in the output register; the back stops popping
//   while it is not taken, the queue fills and then in_chan.ready drops.
// reset:
//   synchronous active-low rst_n empties the queue, drops any pending
//   result and returns the scanner to idle, where items without a start are
//   ignored.
// ----------------------------------------------------------------------------
module inline_markup_delimiter_scanner (
  input  logic       clk,
  input  logic       rst_n,
  imds_in_if.sink    in_chan,
  imds_out_if.source out_chan
);

  // front to queue
  logic              q_push;
  logic              q_full;
  imds_pkg::entry_t  q_push_entry;

  // queue to back
  logic              q_pop;
  logic              q_empty;
  imds_pkg::entry_t  q_pop_entry;

  imds_pkg::result_t result;

  // character classification and input handshake
  imds_front u_front (
    .in_valid          (in_chan.valid),
    .in_ready          (in_chan.ready),
    .in_start_scan     (in_chan.start_scan),
    .in_valid_mask     (in_chan.valid_mask),
    .in_at_column_zero (in_chan.at_column_zero),
    .in_char_code      (in_chan.char_code),
    .in_is_eof         (in_chan.is_eof),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_entry           (q_push_entry)
  );

  // decouples input acceptance from result stalls
  imds_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_pop_entry),
    .empty      (q_empty)
  );

  // scan state machine and registered result
  imds_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_entry    (q_pop_entry),
    .q_pop      (q_pop),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_result (result)
  );

  assign out_chan.found         = result.found;
  assign out_chan.token_kind    = result.kind;
  assign out_chan.token_length  = result.len;
  assign out_chan.skipped_count = result.skipped;

endmodule
